>>> hw/rtl/refcount_deferred_reclaim_table_core_defines.svh
// Assertion macros for the handle table core.
// Used by the top level; expects clock and reset in scope.
`ifndef REFCOUNT_DEFERRED_RECLAIM_TABLE_CORE_DEFINES_SVH
`define REFCOUNT_DEFERRED_RECLAIM_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define RDRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RDRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rdrt_pkg.sv
// Shared constants, codes and controller/datapath types of the handle table.
// No dependencies.
`default_nettype none
package rdrt_pkg;
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int REF_W       = 16;
   localparam int HANDLE_W    = 64;
   localparam int KIND_W      = 4;
   localparam int SLOT_IN_W   = 6;
   localparam int SLOT_OUT_W  = 5;
   localparam int FRAME_W     = 32;
   localparam int CMD_W       = 3;
   localparam int REPLY_W     = 3;
   localparam int KEEP_W      = 8;

   localparam logic [REF_W-1:0]  REF_MAX    = {REF_W{1'b1}};
   localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(3);

   localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADDREF   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FRAME    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

   localparam logic [REPLY_W-1:0] RPL_REGISTERED = 3'd0;
   localparam logic [REPLY_W-1:0] RPL_DESTROYED  = 3'd1;
   localparam logic [REPLY_W-1:0] RPL_DONE       = 3'd2;
   localparam logic [REPLY_W-1:0] RPL_REFS       = 3'd3;
   localparam logic [REPLY_W-1:0] RPL_FULL       = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TAKE,
      OP_INIT,
      OP_REG_RD,
      OP_REG_SEL,
      OP_REG_WR,
      OP_ACC_RD,
      OP_ACC_WR,
      OP_LIST_RD,
      OP_SLOT_RD,
      OP_F1_EV,
      OP_F2_INIT,
      OP_F2_FREE,
      OP_F2_KEEP,
      OP_FL_EV,
      OP_DONE_EM
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             list_more;
      logic             dflag;
      logic             handle_nz;
      logic             out_free;
   } dp_status_type;
endpackage
`default_nettype wire

>>> hw/rtl/rdrt_if.sv
// Request and response channel interfaces of the handle table.
// Depends on rdrt_pkg.
`default_nettype none
interface rdrt_req_if;
   logic                            valid;
   logic                            ready;
   logic [rdrt_pkg::CMD_W-1:0]      cmd;
   logic [rdrt_pkg::HANDLE_W-1:0]   handle_in;
   logic [rdrt_pkg::KIND_W-1:0]     kind_in;
   logic [rdrt_pkg::SLOT_IN_W-1:0]  slot_in;
   logic [rdrt_pkg::FRAME_W-1:0]    frame_now;
   modport source (output valid, cmd, handle_in, kind_in, slot_in, frame_now, input ready);
   modport sink   (input valid, cmd, handle_in, kind_in, slot_in, frame_now, output ready);
endinterface

interface rdrt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rdrt_pkg::REPLY_W-1:0]    reply;
   logic [rdrt_pkg::SLOT_OUT_W-1:0] slot_out;
   logic [rdrt_pkg::HANDLE_W-1:0]   handle_out;
   logic [rdrt_pkg::KIND_W-1:0]     kind_out;
   logic [rdrt_pkg::REF_W-1:0]      refs_out;
   logic [rdrt_pkg::CNT_W-1:0]      destroyed_total;
   logic [rdrt_pkg::CNT_W-1:0]      live_total;
   logic [rdrt_pkg::CNT_W-1:0]      waiting_total;
   logic                            last;
   modport source (output valid, reply, slot_out, handle_out, kind_out, refs_out,
                   destroyed_total, live_total, waiting_total, last, input ready);
   modport sink   (input valid, reply, slot_out, handle_out, kind_out, refs_out,
                   destroyed_total, live_total, waiting_total, last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rdrt_ctrl.sv
// Sequencing state machine of the handle table.
// Depends on rdrt_pkg; drives rdrt_dp through dp_cmd_type.
`default_nettype none
module rdrt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire rdrt_pkg::dp_status_type status,
   output rdrt_pkg::dp_cmd_type         command
);
   typedef enum logic [16:0] {
      S_IDLE    = 17'h00001,
      S_DISP    = 17'h00002,
      S_REG_RD  = 17'h00004,
      S_REG_SEL = 17'h00008,
      S_REG_WR  = 17'h00010,
      S_ACC_RD  = 17'h00020,
      S_ACC_WR  = 17'h00040,
      S_F1_RD   = 17'h00080,
      S_F1_SL   = 17'h00100,
      S_F1_EV   = 17'h00200,
      S_F2_RD   = 17'h00400,
      S_F2_SL   = 17'h00800,
      S_F2_EV   = 17'h01000,
      S_FL_RD   = 17'h02000,
      S_FL_SL   = 17'h04000,
      S_FL_EV   = 17'h08000,
      S_DONE    = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      command.op = rdrt_pkg::OP_NONE;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               command.op = rdrt_pkg::OP_TAKE;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            command.op = rdrt_pkg::OP_INIT;
            case (status.cmd) inside
               rdrt_pkg::CMD_REGISTER: state_in = S_REG_RD;
               rdrt_pkg::CMD_ADDREF, rdrt_pkg::CMD_RELEASE, rdrt_pkg::CMD_QUERY:
                  state_in = S_ACC_RD;
               rdrt_pkg::CMD_FRAME: state_in = S_F1_RD;
               rdrt_pkg::CMD_FLUSH: state_in = S_FL_RD;
               default: state_in = S_DONE;
            endcase
         end
         S_REG_RD: begin
            command.op = rdrt_pkg::OP_REG_RD;
            state_in   = S_REG_SEL;
         end
         S_REG_SEL: begin
            command.op = rdrt_pkg::OP_REG_SEL;
            state_in   = S_REG_WR;
         end
         S_REG_WR: begin
            if (status.out_free) begin
               command.op = rdrt_pkg::OP_REG_WR;
               state_in   = S_IDLE;
            end
         end
         S_ACC_RD: begin
            command.op = rdrt_pkg::OP_ACC_RD;
            state_in   = S_ACC_WR;
         end
         S_ACC_WR: begin
            if (status.out_free) begin
               command.op = rdrt_pkg::OP_ACC_WR;
               state_in   = S_IDLE;
            end
         end
         S_F1_RD: begin
            if (status.list_more) begin
               command.op = rdrt_pkg::OP_LIST_RD;
               state_in   = S_F1_SL;
            end else begin
               command.op = rdrt_pkg::OP_F2_INIT;
               state_in   = S_F2_RD;
            end
         end
         S_F1_SL: begin
            command.op = rdrt_pkg::OP_SLOT_RD;
            state_in   = S_F1_EV;
         end
         S_F1_EV: begin
            command.op = rdrt_pkg::OP_F1_EV;
            state_in   = S_F1_RD;
         end
         S_F2_RD: begin
            if (status.list_more) begin
               command.op = rdrt_pkg::OP_LIST_RD;
               state_in   = S_F2_SL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_F2_SL: begin
            command.op = rdrt_pkg::OP_SLOT_RD;
            state_in   = S_F2_EV;
         end
         S_F2_EV: begin
            if (!status.dflag) begin
               command.op = rdrt_pkg::OP_F2_KEEP;
               state_in   = S_F2_RD;
            end else if (status.out_free) begin
               command.op = rdrt_pkg::OP_F2_FREE;
               state_in   = S_F2_RD;
            end
         end
         S_FL_RD: begin
            if (status.list_more) begin
               command.op = rdrt_pkg::OP_LIST_RD;
               state_in   = S_FL_SL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FL_SL: begin
            command.op = rdrt_pkg::OP_SLOT_RD;
            state_in   = S_FL_EV;
         end
         S_FL_EV: begin
            if (!status.handle_nz || status.out_free) begin
               command.op = rdrt_pkg::OP_FL_EV;
               state_in   = S_FL_RD;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               command.op = rdrt_pkg::OP_DONE_EM;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/rdrt_dp.sv
// Datapath of the handle table: entry memories, free stack, pending list,
// counters and the response register. Depends on rdrt_pkg and rdrt_if.
`default_nettype none
module rdrt_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rdrt_pkg::dp_cmd_type              command,
   output rdrt_pkg::dp_status_type                status,
   input  wire logic [rdrt_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [rdrt_pkg::HANDLE_W-1:0]     req_handle,
   input  wire logic [rdrt_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [rdrt_pkg::SLOT_IN_W-1:0]    req_slot,
   input  wire logic [rdrt_pkg::FRAME_W-1:0]      req_frame,
   input  wire logic                              csr_write_enable,
   input  wire logic [rdrt_pkg::KEEP_W-1:0]       csr_write_data,
   rdrt_rsp_if.source                             rsp_chan
);
   localparam int D = rdrt_pkg::TABLE_DEPTH;
   localparam int IW = rdrt_pkg::IDX_W;
   localparam int CW = rdrt_pkg::CNT_W;
   localparam int RW = rdrt_pkg::REF_W;
   localparam int FW = rdrt_pkg::FRAME_W;

   // latched item
   logic [rdrt_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [rdrt_pkg::HANDLE_W-1:0]  handle_ff, handle_in;
   logic [rdrt_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [rdrt_pkg::SLOT_IN_W-1:0] slot_ff, slot_in;
   logic [FW-1:0]                  frame_ff, frame_in;
   logic [rdrt_pkg::KEEP_W-1:0]    keep_ff;

   // control state
   logic [CW-1:0] slots_used_ff, slots_used_in, free_top_ff, free_top_in;
   logic [CW-1:0] pend_len_ff, pend_len_in, live_ff, live_in;
   logic [CW-1:0] idx_ff, idx_in, wr_ff, wr_in, dcount_ff, dcount_in;
   logic [D-1:0]  free_bits_ff, free_bits_in, pend_bits_ff, pend_bits_in;
   logic [D-1:0]  stamped_ff, stamped_in, dflag_ff, dflag_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic          reg_ok_ff, reg_ok_in, reg_reuse_ff, reg_reuse_in;

   // memories and their registered read data
   logic [rdrt_pkg::HANDLE_W-1:0] handle_mem [D];
   logic [rdrt_pkg::KIND_W-1:0]   kind_mem   [D];
   logic [RW-1:0]                 refs_mem   [D];
   logic [FW-1:0]                 stamp_mem  [D];
   logic [IW-1:0]                 fstack_mem [D];
   logic [IW-1:0]                 plist_mem  [D];
   logic [rdrt_pkg::HANDLE_W-1:0] handle_q_ff;
   logic [rdrt_pkg::KIND_W-1:0]   kind_q_ff;
   logic [RW-1:0]                 refs_q_ff;
   logic [FW-1:0]                 stamp_q_ff;
   logic [IW-1:0]                 fstack_q_ff, plist_q_ff;

   logic          ent_re, ent_we, refs_we, stamp_we, fs_re, fs_we, pl_re, pl_we;
   logic [IW-1:0] ent_raddr, refs_waddr, fs_waddr, pl_waddr, pl_wdata, fs_wdata;
   logic [RW-1:0] refs_wdata;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rdrt_pkg::REPLY_W-1:0]      o_reply_ff, o_reply_in;
   logic [rdrt_pkg::SLOT_OUT_W-1:0]   o_slot_ff, o_slot_in;
   logic [rdrt_pkg::HANDLE_W-1:0]     o_handle_ff, o_handle_in;
   logic [rdrt_pkg::KIND_W-1:0]       o_kind_ff, o_kind_in;
   logic [RW-1:0]                     o_refs_ff, o_refs_in;
   logic [CW-1:0]                     o_dest_ff, o_dest_in, o_live_ff, o_live_in;
   logic [CW-1:0]                     o_wait_ff, o_wait_in;
   logic                              o_last_ff, o_last_in;
   logic                              out_load;

   logic          reuse, fresh_ok, valid_id, acc_ok;
   logic [IW-1:0] sel_slot, slot_idx, idx_lo;
   logic [CW-1:0] wait_walk;
   logic [FW-1:0] stamp_eff;

   assign reuse     = (free_top_ff != '0);
   assign fresh_ok  = (slots_used_ff < CW'(D));
   assign sel_slot  = reuse ? fstack_q_ff : slots_used_ff[IW-1:0];
   assign slot_idx  = slot_ff[IW-1:0];
   assign idx_lo    = idx_ff[IW-1:0];
   assign valid_id  = (slot_ff < rdrt_pkg::SLOT_IN_W'(slots_used_ff));
   assign acc_ok    = valid_id && !free_bits_ff[slot_idx];
   assign wait_walk = (cmd_ff == rdrt_pkg::CMD_FLUSH) ? '0 : (pend_len_ff - dcount_ff);
   assign stamp_eff = stamped_ff[cur_ff] ? stamp_q_ff : frame_ff;

   always_comb begin
      cmd_in = cmd_ff;  handle_in = handle_ff;  kind_in = kind_ff;
      slot_in = slot_ff;  frame_in = frame_ff;
      slots_used_in = slots_used_ff;  free_top_in = free_top_ff;
      pend_len_in = pend_len_ff;  live_in = live_ff;
      idx_in = idx_ff;  wr_in = wr_ff;  dcount_in = dcount_ff;
      free_bits_in = free_bits_ff;  pend_bits_in = pend_bits_ff;
      stamped_in = stamped_ff;  dflag_in = dflag_ff;
      cur_in = cur_ff;  reg_ok_in = reg_ok_ff;  reg_reuse_in = reg_reuse_ff;
      ent_re = 1'b0;  ent_we = 1'b0;  refs_we = 1'b0;  stamp_we = 1'b0;
      fs_re = 1'b0;  fs_we = 1'b0;  pl_re = 1'b0;  pl_we = 1'b0;
      ent_raddr = plist_q_ff;  refs_waddr = cur_ff;  refs_wdata = RW'(1);
      fs_waddr = free_top_ff[IW-1:0];  fs_wdata = cur_ff;
      pl_waddr = wr_ff[IW-1:0];  pl_wdata = cur_ff;
      out_load = 1'b0;
      o_reply_in = rdrt_pkg::RPL_DONE;  o_slot_in = '0;  o_handle_in = '0;
      o_kind_in = '0;  o_refs_in = '0;  o_dest_in = '0;
      o_live_in = live_ff;  o_wait_in = pend_len_ff;  o_last_in = 1'b1;

      case (command.op)
         rdrt_pkg::OP_TAKE: begin
            cmd_in = req_cmd;  handle_in = req_handle;  kind_in = req_kind;
            slot_in = req_slot;  frame_in = req_frame;
         end
         rdrt_pkg::OP_INIT: begin
            idx_in = '0;  wr_in = '0;  dcount_in = '0;  dflag_in = '0;
         end
         rdrt_pkg::OP_REG_RD: fs_re = 1'b1;
         rdrt_pkg::OP_REG_SEL: begin
            ent_raddr    = sel_slot;
            ent_re       = 1'b1;
            cur_in       = sel_slot;
            reg_ok_in    = reuse || fresh_ok;
            reg_reuse_in = reuse;
         end
         rdrt_pkg::OP_REG_WR: begin
            out_load = 1'b1;
            if (reg_ok_ff) begin
               ent_we  = 1'b1;
               refs_we = 1'b1;
               stamped_in[cur_ff]   = 1'b0;
               free_bits_in[cur_ff] = 1'b0;
               if (reg_reuse_ff) begin
                  free_top_in = free_top_ff - CW'(1);
               end else begin
                  slots_used_in = slots_used_ff + CW'(1);
               end
               // a reused slot may have been revived before it was freed
               if (!reg_reuse_ff || refs_q_ff == '0) begin
                  live_in = live_ff + CW'(1);
               end
               o_reply_in = rdrt_pkg::RPL_REGISTERED;
               o_slot_in  = cur_ff;
            end else begin
               o_reply_in = rdrt_pkg::RPL_FULL;
            end
            o_live_in = live_in;
         end
         rdrt_pkg::OP_ACC_RD: begin
            ent_raddr = slot_idx;
            ent_re    = 1'b1;
         end
         rdrt_pkg::OP_ACC_WR: begin
            out_load   = 1'b1;
            refs_waddr = slot_idx;
            pl_waddr   = pend_len_ff[IW-1:0];
            pl_wdata   = slot_idx;
            case (cmd_ff)
               rdrt_pkg::CMD_ADDREF: begin
                  if (acc_ok && refs_q_ff != rdrt_pkg::REF_MAX) begin
                     refs_we    = 1'b1;
                     refs_wdata = refs_q_ff + RW'(1);
                     if (refs_q_ff == '0) live_in = live_ff + CW'(1);
                  end
               end
               rdrt_pkg::CMD_RELEASE: begin
                  if (acc_ok && refs_q_ff != '0) begin
                     refs_we    = 1'b1;
                     refs_wdata = refs_q_ff - RW'(1);
                     if (refs_q_ff == RW'(1)) begin
                        live_in = live_ff - CW'(1);
                        if (!pend_bits_ff[slot_idx] && pend_len_ff < CW'(D)) begin
                           pl_we                  = 1'b1;
                           pend_len_in            = pend_len_ff + CW'(1);
                           pend_bits_in[slot_idx] = 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  o_reply_in = rdrt_pkg::RPL_REFS;
                  o_slot_in  = slot_idx;
                  o_refs_in  = valid_id ? refs_q_ff : '0;
               end
            endcase
            o_live_in = live_in;
            o_wait_in = pend_len_in;
         end
         rdrt_pkg::OP_LIST_RD: pl_re = 1'b1;
         rdrt_pkg::OP_SLOT_RD: begin
            ent_re = 1'b1;
            cur_in = plist_q_ff;
         end
         rdrt_pkg::OP_F1_EV: begin
            if (!stamped_ff[cur_ff]) begin
               stamp_we           = 1'b1;
               stamped_in[cur_ff] = 1'b1;
            end
            if ((FW + 1)'(frame_ff) >= (FW + 1)'(stamp_eff) + (FW + 1)'(keep_ff)) begin
               dflag_in[idx_lo] = 1'b1;
               dcount_in        = dcount_ff + CW'(1);
            end
            idx_in = idx_ff + CW'(1);
         end
         rdrt_pkg::OP_F2_INIT: begin
            idx_in = '0;
            wr_in  = '0;
         end
         rdrt_pkg::OP_F2_KEEP: begin
            pl_we  = 1'b1;
            wr_in  = wr_ff + CW'(1);
            idx_in = idx_ff + CW'(1);
         end
         rdrt_pkg::OP_F2_FREE, rdrt_pkg::OP_FL_EV: begin
            if (command.op == rdrt_pkg::OP_F2_FREE || handle_q_ff != '0) begin
               out_load    = 1'b1;
               o_reply_in  = rdrt_pkg::RPL_DESTROYED;
               o_slot_in   = cur_ff;
               o_handle_in = handle_q_ff;
               o_kind_in   = kind_q_ff;
               o_last_in   = 1'b0;
               o_wait_in   = wait_walk;
               if (command.op == rdrt_pkg::OP_FL_EV) dcount_in = dcount_ff + CW'(1);
            end
            stamped_in[cur_ff]   = 1'b0;
            pend_bits_in[cur_ff] = 1'b0;
            if (!free_bits_ff[cur_ff] && free_top_ff < CW'(D)) begin
               fs_we                = 1'b1;
               free_top_in          = free_top_ff + CW'(1);
               free_bits_in[cur_ff] = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
         end
         rdrt_pkg::OP_DONE_EM: begin
            out_load = 1'b1;
            if (cmd_ff == rdrt_pkg::CMD_FRAME) begin
               pend_len_in = wr_ff;
            end else if (cmd_ff == rdrt_pkg::CMD_FLUSH) begin
               pend_len_in = '0;
            end
            o_dest_in = dcount_ff;
            o_wait_in = pend_len_in;
         end
         default: ;
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || out_load;
   end

   // memories
   always_ff @(posedge clock) begin
      if (ent_we) begin
         handle_mem[cur_ff] <= handle_ff;
         kind_mem[cur_ff]   <= kind_ff;
      end
      if (refs_we) refs_mem[refs_waddr] <= refs_wdata;
      if (stamp_we) stamp_mem[cur_ff] <= frame_ff;
      if (fs_we) fstack_mem[fs_waddr] <= fs_wdata;
      if (pl_we) plist_mem[pl_waddr] <= pl_wdata;
      if (ent_re) begin
         handle_q_ff <= handle_mem[ent_raddr];
         kind_q_ff   <= kind_mem[ent_raddr];
         refs_q_ff   <= refs_mem[ent_raddr];
         stamp_q_ff  <= stamp_mem[ent_raddr];
      end
      if (fs_re) fstack_q_ff <= fstack_mem[free_top_ff[IW-1:0] - IW'(1)];
      if (pl_re) plist_q_ff <= plist_mem[idx_lo];
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_in_hold: begin
         cmd_ff <= cmd_in;  handle_ff <= handle_in;  kind_ff <= kind_in;
         slot_ff <= slot_in;  frame_ff <= frame_in;
         cur_ff <= cur_in;  reg_ok_ff <= reg_ok_in;  reg_reuse_ff <= reg_reuse_in;
         idx_ff <= idx_in;  wr_ff <= wr_in;  dcount_ff <= dcount_in;  dflag_ff <= dflag_in;
      end
      if (out_load) begin
         o_reply_ff <= o_reply_in;  o_slot_ff <= o_slot_in;  o_handle_ff <= o_handle_in;
         o_kind_ff <= o_kind_in;  o_refs_ff <= o_refs_in;  o_dest_ff <= o_dest_in;
         o_live_ff <= o_live_in;  o_wait_ff <= o_wait_in;  o_last_ff <= o_last_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff       <= rdrt_pkg::KEEP_RESET;
         slots_used_ff <= '0;
         free_top_ff   <= '0;
         pend_len_ff   <= '0;
         live_ff       <= '0;
         free_bits_ff  <= '0;
         pend_bits_ff  <= '0;
         stamped_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) keep_ff <= csr_write_data;
         slots_used_ff <= slots_used_in;
         free_top_ff   <= free_top_in;
         pend_len_ff   <= pend_len_in;
         live_ff       <= live_in;
         free_bits_ff  <= free_bits_in;
         pend_bits_ff  <= pend_bits_in;
         stamped_ff    <= stamped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign status.cmd       = cmd_ff;
   assign status.list_more = (idx_ff < pend_len_ff);
   assign status.dflag     = dflag_ff[idx_lo];
   assign status.handle_nz = (handle_q_ff != '0);
   assign status.out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.reply           = o_reply_ff;
   assign rsp_chan.slot_out        = o_slot_ff;
   assign rsp_chan.handle_out      = o_handle_ff;
   assign rsp_chan.kind_out        = o_kind_ff;
   assign rsp_chan.refs_out        = o_refs_ff;
   assign rsp_chan.destroyed_total = o_dest_ff;
   assign rsp_chan.live_total      = o_live_ff;
   assign rsp_chan.waiting_total   = o_wait_ff;
   assign rsp_chan.last            = o_last_ff;
endmodule
`default_nettype wire

>>> hw/rtl/refcount_deferred_reclaim_table_core.sv
// Top level of the reference-counted handle table with deferred reclaim.
// Depends on rdrt_pkg, rdrt_if, rdrt_ctrl, rdrt_dp and the defines header.
//
// Usage:
//  - req_chan carries one command per beat (register, addref, release, process
//    frame, flush, query); it is taken when valid and ready are both high.
//  - rsp_chan returns the result beats of that command in order; the final beat
//    of each command has last set. Frame sends one destroyed beat per reclaimed
//    entry and flush one per reclaimed entry with a nonzero handle, then a done beat.
//  - csr_write_enable/csr_write_data load keep_alive_frames (reset value 3);
//    write it only while no command is in work.
// Timing: one command at a time. A frame command walks the pending list twice
//  (stamp and decide, then emit and compact); flush walks it once. Entry
//  memories have one registered read port, so each entry takes a list read,
//  a slot read and an evaluate step in turn.
// Reset: synchronous, active high; empties the table, free stack and pending
//  list and returns keep_alive_frames to 3. No memory clearing pass is needed.
// Stall: a held response beat stays in the output register; the walk pauses
//  on an entry that must be reported until the beat is taken.
`default_nettype none
`include "refcount_deferred_reclaim_table_core_defines.svh"
module refcount_deferred_reclaim_table_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rdrt_req_if.sink                            req_chan,
   rdrt_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_write_enable,
   input  wire logic [rdrt_pkg::KEEP_W-1:0]    csr_write_data
);
   rdrt_pkg::dp_cmd_type    command;
   rdrt_pkg::dp_status_type status;
   logic                    req_ready;

   assign req_chan.ready = req_ready;

   // sequence each command through the datapath steps
   rdrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .command   (command)
   );

   // hold the table state and drive the response register
   rdrt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .command          (command),
      .status           (status),
      .req_cmd          (req_chan.cmd),
      .req_handle       (req_chan.handle_in),
      .req_kind         (req_chan.kind_in),
      .req_slot         (req_chan.slot_in),
      .req_frame        (req_chan.frame_now),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_chan         (rsp_chan)
   );

   // a taken beat blocks the input until the command has finished
   `RDRT_ASSERT_NEXT(a_busy_after_take, req_chan.valid && req_chan.ready, !req_chan.ready, "input taken while a command is in work")
   // only destroyed beats may precede the final beat of a command
   `RDRT_ASSERT_NOW(a_mid_beat_destroyed, rsp_chan.valid && !rsp_chan.last, rsp_chan.reply == rdrt_pkg::RPL_DESTROYED, "non-final beat is not a destroyed report")
   // live and waiting totals never exceed the table size
   `RDRT_ASSERT_NOW(a_totals_bounded, rsp_chan.valid, (rsp_chan.live_total <= rdrt_pkg::TABLE_DEPTH) && (rsp_chan.waiting_total <= rdrt_pkg::TABLE_DEPTH), "live or waiting total out of range")
endmodule
`default_nettype wire

>>> tb/sv/tb_rdrt_pkg.sv
// Shared test constants and the predicted result beat type for the handle table testbench.
// Depends on rdrt_pkg.
`timescale 1ns / 100ps
package tb_rdrt_pkg;
   // codes outside the defined command set
   localparam logic [rdrt_pkg::CMD_W-1:0] CMD_UNKNOWN_A = 3'd6;
   localparam logic [rdrt_pkg::CMD_W-1:0] CMD_UNKNOWN_B = 3'd7;

   typedef struct packed {
      logic [rdrt_pkg::REPLY_W-1:0]    reply;
      logic [rdrt_pkg::SLOT_OUT_W-1:0] slot_out;
      logic [rdrt_pkg::HANDLE_W-1:0]   handle_out;
      logic [rdrt_pkg::KIND_W-1:0]     kind_out;
      logic [rdrt_pkg::REF_W-1:0]      refs_out;
      logic [rdrt_pkg::CNT_W-1:0]      destroyed_total;
      logic [rdrt_pkg::CNT_W-1:0]      live_total;
      logic [rdrt_pkg::CNT_W-1:0]      waiting_total;
      logic                            last;
   } rsp_beat_type;
endpackage

>>> tb/sv/tb_rdrt_if.sv
// Testbench-side view of the handle table channels; reuses the RTL interfaces.
// Depends on rdrt_pkg, compiled before this file.
`timescale 1ns / 100ps
// The channel interfaces rdrt_req_if and rdrt_rsp_if come from the RTL; this file
// only groups the config-port bundle that the checker taps.
interface tb_csr_if;
   logic                       write_enable;
   logic [rdrt_pkg::KEEP_W-1:0] write_data;
   modport source (output write_enable, write_data);
   modport sink   (input write_enable, write_data);
endinterface

>>> tb/sv/rdrt_table_checker.sv
// Handle table predictor and result scoreboard; watches the channels beside the block.
// Depends on rdrt_pkg, tb_rdrt_pkg, rdrt_if and tb_csr_if.
`timescale 1ns / 100ps
module rdrt_table_checker (
   input  wire logic clock,
   input  wire logic reset,
   rdrt_req_if       req,
   rdrt_rsp_if       rsp,
   tb_csr_if         csr,
   output int        fail_count,
   output int        beats_owed
);
   localparam int TABLE_DEPTH = rdrt_pkg::TABLE_DEPTH;
   localparam int CNT_W       = rdrt_pkg::CNT_W;
   localparam int SLOT_OUT_W  = rdrt_pkg::SLOT_OUT_W;

   logic [rdrt_pkg::KEEP_W-1:0]   keep_frames;
   logic [rdrt_pkg::HANDLE_W-1:0] ent_handle [TABLE_DEPTH];
   logic [rdrt_pkg::KIND_W-1:0]   ent_kind   [TABLE_DEPTH];
   logic [rdrt_pkg::REF_W-1:0]    ent_refs   [TABLE_DEPTH];
   logic [rdrt_pkg::FRAME_W-1:0]  ent_stamp  [TABLE_DEPTH];
   logic                          ent_stamped[TABLE_DEPTH];
   int                            used_slots;
   int                            free_lifo[$];
   int                            reclaim_list[$];
   tb_rdrt_pkg::rsp_beat_type     owed_beats[$];

   function automatic tb_rdrt_pkg::rsp_beat_type blank_beat(
         logic [rdrt_pkg::REPLY_W-1:0] r);
      tb_rdrt_pkg::rsp_beat_type b;
      b = '0;
      b.reply = r;
      return b;
   endfunction

   function automatic bit is_freed(int s);
      foreach (free_lifo[i]) if (free_lifo[i] == s) return 1;
      return 0;
   endfunction

   function automatic void drop_entry(int s);
      ent_handle[s]  = '0;
      ent_stamped[s] = 1'b0;
      if (!is_freed(s)) free_lifo = {free_lifo, s};
   endfunction

   // compute the beats of one command and advance the table copy
   function automatic void predict_command(logic [rdrt_pkg::CMD_W-1:0] cmd,
                                           logic [rdrt_pkg::HANDLE_W-1:0] h,
                                           logic [rdrt_pkg::KIND_W-1:0] k,
                                           logic [rdrt_pkg::SLOT_IN_W-1:0] sl,
                                           logic [rdrt_pkg::FRAME_W-1:0] fr);
      tb_rdrt_pkg::rsp_beat_type beats[$];
      tb_rdrt_pkg::rsp_beat_type b;
      int        id, s, live, gone, pend;
      bit        known;
      int        kept[$];
      id    = sl;
      known = id < used_slots;
      gone  = 0;
      case (cmd)
         rdrt_pkg::CMD_REGISTER: begin
            if (free_lifo.size() > 0) begin
               s = free_lifo[free_lifo.size() - 1];
               free_lifo.delete(free_lifo.size() - 1);
            end else if (used_slots < TABLE_DEPTH) s = used_slots++;
            else s = -1;
            if (s >= 0) begin
               ent_handle[s] = h; ent_kind[s] = k; ent_refs[s] = 1; ent_stamped[s] = 0;
               b = blank_beat(rdrt_pkg::RPL_REGISTERED);
               b.slot_out = s[SLOT_OUT_W-1:0];
            end else begin
               b = blank_beat(rdrt_pkg::RPL_FULL);
            end
            beats = {beats, b};
         end
         rdrt_pkg::CMD_ADDREF: begin
            if (known && !is_freed(id) && ent_refs[id] != rdrt_pkg::REF_MAX) ent_refs[id]++;
            beats = {beats, blank_beat(rdrt_pkg::RPL_DONE)};
         end
         rdrt_pkg::CMD_RELEASE: begin
            if (known && !is_freed(id) && ent_refs[id] != 0) begin
               ent_refs[id]--;
               if (ent_refs[id] == 0) begin
                  bit listed;
                  listed = 0;
                  foreach (reclaim_list[i]) if (reclaim_list[i] == id) listed = 1;
                  if (!listed) reclaim_list = {reclaim_list, id};
               end
            end
            beats = {beats, blank_beat(rdrt_pkg::RPL_DONE)};
         end
         rdrt_pkg::CMD_FRAME: begin
            foreach (reclaim_list[i]) begin
               s = reclaim_list[i];
               if (!ent_stamped[s]) begin ent_stamp[s] = fr; ent_stamped[s] = 1; end
               // widen so the sum never wraps
               if ({1'b0, fr} >= {1'b0, ent_stamp[s]} + keep_frames) begin
                  b = blank_beat(rdrt_pkg::RPL_DESTROYED);
                  b.slot_out = s[SLOT_OUT_W-1:0];
                  b.handle_out = ent_handle[s];
                  b.kind_out = ent_kind[s];
                  beats = {beats, b};
                  drop_entry(s);
                  gone++;
               end else begin
                  kept = {kept, s};
               end
            end
            reclaim_list = kept;
            b = blank_beat(rdrt_pkg::RPL_DONE);
            b.destroyed_total = gone[CNT_W-1:0];
            beats = {beats, b};
         end
         rdrt_pkg::CMD_FLUSH: begin
            foreach (reclaim_list[i]) begin
               s = reclaim_list[i];
               if (ent_handle[s] != 0) begin
                  b = blank_beat(rdrt_pkg::RPL_DESTROYED);
                  b.slot_out = s[SLOT_OUT_W-1:0];
                  b.handle_out = ent_handle[s];
                  b.kind_out = ent_kind[s];
                  beats = {beats, b};
                  gone++;
               end
               drop_entry(s);
            end
            reclaim_list.delete();
            b = blank_beat(rdrt_pkg::RPL_DONE);
            b.destroyed_total = gone[CNT_W-1:0];
            beats = {beats, b};
         end
         rdrt_pkg::CMD_QUERY: begin
            b = blank_beat(rdrt_pkg::RPL_REFS);
            b.slot_out = sl[SLOT_OUT_W-1:0];
            b.refs_out = known ? ent_refs[id] : '0;
            beats = {beats, b};
         end
         default: beats = {beats, blank_beat(rdrt_pkg::RPL_DONE)};
      endcase
      live = 0;
      for (int i = 0; i < used_slots; i++) if (ent_refs[i] != 0) live++;
      pend = reclaim_list.size();
      foreach (beats[i]) begin
         beats[i].live_total    = live[CNT_W-1:0];
         beats[i].waiting_total = pend[CNT_W-1:0];
         beats[i].last          = (i == beats.size() - 1);
         owed_beats = {owed_beats, beats[i]};
      end
   endfunction

   assign beats_owed = owed_beats.size();

   always @(posedge clock) begin
      tb_rdrt_pkg::rsp_beat_type got, want;
      if (reset) begin
         fail_count  = 0;
         keep_frames = rdrt_pkg::KEEP_RESET;
         used_slots  = 0;
         free_lifo.delete();
         reclaim_list.delete();
         owed_beats.delete();
         foreach (ent_stamped[i]) begin
            ent_stamped[i] = 0; ent_refs[i] = 0; ent_handle[i] = 0;
         end
      end else begin
         if (csr.write_enable) keep_frames = csr.write_data;
         if (req.valid && req.ready)
            predict_command(req.cmd, req.handle_in, req.kind_in, req.slot_in, req.frame_now);
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.reply, rsp.slot_out, rsp.handle_out, rsp.kind_out, rsp.refs_out,
                    rsp.destroyed_total, rsp.live_total, rsp.waiting_total, rsp.last};
            if (owed_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %p", got);
            end else begin
               want = owed_beats.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end
endmodule

>>> tb/sv/tb_refcount_deferred_reclaim_table_core.sv
// Top of the handle table testbench: clock, reset, stimulus, stall patterns and verdict.
// Depends on rdrt_pkg, tb_rdrt_pkg, the channel interfaces and rdrt_table_checker.
`timescale 1ns / 100ps
module tb_refcount_deferred_reclaim_table_core;
   localparam int IDLE_LIMIT = 20000;
   localparam int CMD_W      = rdrt_pkg::CMD_W;
   localparam int HANDLE_W   = rdrt_pkg::HANDLE_W;
   localparam int KIND_W     = rdrt_pkg::KIND_W;
   localparam int SLOT_IN_W  = rdrt_pkg::SLOT_IN_W;
   localparam int FRAME_W    = rdrt_pkg::FRAME_W;
   localparam int KEEP_W     = rdrt_pkg::KEEP_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, beats_owed;
   int   idle_cycles = 0;
   logic [FRAME_W-1:0] frame_clock = '0;

   rdrt_req_if req_chan ();
   rdrt_rsp_if rsp_chan ();
   tb_csr_if   csr ();

   refcount_deferred_reclaim_table_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr.write_enable),
      .csr_write_data   (csr.write_data)
   );

   rdrt_table_checker checker_u (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .csr        (csr),
      .fail_count (fail_count),
      .beats_owed (beats_owed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver stalls: alternate open stretches with random stall patterns.
   initial begin
      int mode;
      rsp_chan.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(10, 80)) begin
            @(posedge clock);
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ~rsp_chan.ready;
            endcase
         end
      end
   end

   // Watchdog: count cycles where no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   int burst_left = 0;

   // Drive one command; hold it until the block takes the beat. Gaps fall
   // between bursts, so valid stays high across back-to-back beats.
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h,
                           logic [KIND_W-1:0] k, logic [SLOT_IN_W-1:0] sl,
                           logic [FRAME_W-1:0] fr);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= cmd;
      req_chan.handle_in <= h;
      req_chan.kind_in   <= k;
      req_chan.slot_in   <= sl;
      req_chan.frame_now <= fr;
      do @(posedge clock); while (!req_chan.ready);
      if (burst_left == 0) req_chan.valid <= 1'b0;
   endtask

   function automatic logic [HANDLE_W-1:0] rand_handle();
      return {$urandom(), $urandom()};
   endfunction

   // Drain all owed beats, then let the block settle before a register write.
   task automatic quiesce();
      @(posedge clock);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (beats_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_keep(logic [KEEP_W-1:0] v);
      quiesce();
      csr.write_enable <= 1'b1;
      csr.write_data   <= v;
      @(posedge clock);
      csr.write_enable <= 1'b0;
   endtask

   // Random phase: mostly register/release/frame cycles with random content.
   task automatic random_phase(int n);
      int pick;
      logic [CMD_W-1:0] cmd;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) cmd = rdrt_pkg::CMD_REGISTER;
         else if (pick < 40) cmd = rdrt_pkg::CMD_ADDREF;
         else if (pick < 65) cmd = rdrt_pkg::CMD_RELEASE;
         else if (pick < 82) cmd = rdrt_pkg::CMD_FRAME;
         else if (pick < 86) cmd = rdrt_pkg::CMD_FLUSH;
         else if (pick < 97) cmd = rdrt_pkg::CMD_QUERY;
         else cmd = CMD_W'($urandom_range(tb_rdrt_pkg::CMD_UNKNOWN_A,
                                          tb_rdrt_pkg::CMD_UNKNOWN_B));
         // advance frames mostly by small steps so stamps age gradually
         if (cmd == rdrt_pkg::CMD_FRAME) begin
            if ($urandom_range(0, 19) == 0) frame_clock = $urandom();
            else frame_clock = frame_clock + $urandom_range(0, 4);
         end
         send_cmd(cmd, ($urandom_range(0, 7) == 0) ? '0 : rand_handle(),
                  KIND_W'($urandom_range(0, 15)),
                  ($urandom_range(0, 9) == 0) ? SLOT_IN_W'($urandom_range(0, 63))
                                              : SLOT_IN_W'($urandom_range(0, 33)),
                  frame_clock);
      end
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.cmd <= rdrt_pkg::CMD_REGISTER;
      req_chan.handle_in <= '0;
      req_chan.kind_in <= '0;
      req_chan.slot_in <= '0;
      req_chan.frame_now <= '0;
      csr.write_enable <= 1'b0;
      csr.write_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero handle, unused ids, release at zero, revive.
      send_cmd(rdrt_pkg::CMD_QUERY, '0, '0, 6'd0, '0);           // empty table query
      send_cmd(rdrt_pkg::CMD_REGISTER, '1, 4'hF, '0, '0);
      send_cmd(rdrt_pkg::CMD_REGISTER, '0, 4'h0, '0, '0);        // zero handle
      send_cmd(rdrt_pkg::CMD_ADDREF, '0, '0, 6'd63, '0);         // unused id
      send_cmd(rdrt_pkg::CMD_RELEASE, '0, '0, 6'd1, '0);
      send_cmd(rdrt_pkg::CMD_RELEASE, '0, '0, 6'd1, '0);         // release at zero
      send_cmd(rdrt_pkg::CMD_RELEASE, '0, '0, 6'd0, '0);
      send_cmd(rdrt_pkg::CMD_ADDREF, '0, '0, 6'd0, '0);          // revive while pending
      send_cmd(rdrt_pkg::CMD_RELEASE, '0, '0, 6'd0, '0);         // already pending
      send_cmd(rdrt_pkg::CMD_FRAME, '0, '0, '0, 32'hFFFF_FFFE);  // stamp near the top
      send_cmd(rdrt_pkg::CMD_FRAME, '0, '0, '0, 32'hFFFF_FFFF);  // no wrap of stamp sum
      send_cmd(rdrt_pkg::CMD_FLUSH, '0, '0, '0, '0);             // zero handle not reported
      send_cmd(rdrt_pkg::CMD_ADDREF, '0, '0, 6'd1, '0);          // freed slot ignored
      send_cmd(rdrt_pkg::CMD_QUERY, '0, '0, 6'd33, '0);
      send_cmd(tb_rdrt_pkg::CMD_UNKNOWN_A, '1, '1, '1, '1);
      send_cmd(tb_rdrt_pkg::CMD_UNKNOWN_B, '0, '0, '0, '0);
      // fill the table until it reports full
      repeat (33) send_cmd(rdrt_pkg::CMD_REGISTER, rand_handle(),
                           KIND_W'($urandom_range(0, 15)), '0, '0);
      for (int i = 0; i < 32; i++)
         send_cmd(rdrt_pkg::CMD_RELEASE, '0, '0, i[SLOT_IN_W-1:0], '0);
      send_cmd(rdrt_pkg::CMD_FRAME, '0, '0, '0, 32'd10);
      send_cmd(rdrt_pkg::CMD_FRAME, '0, '0, '0, 32'd13);         // all reclaimed at once

      write_keep(8'd0);
      random_phase(45);
      write_keep(8'd255);
      random_phase(40);
      write_keep(8'd1);
      random_phase(41);
      write_keep(rdrt_pkg::KEEP_RESET);
      send_cmd(rdrt_pkg::CMD_FLUSH, '0, '0, '0, '0);

      quiesce();
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

>>> refcount_deferred_reclaim_table_core.f
+incdir+hw/rtl
hw/rtl/rdrt_pkg.sv
hw/rtl/rdrt_if.sv
hw/rtl/rdrt_ctrl.sv
hw/rtl/rdrt_dp.sv
hw/rtl/refcount_deferred_reclaim_table_core.sv
tb/sv/tb_rdrt_pkg.sv
tb/sv/tb_rdrt_if.sv
tb/sv/rdrt_table_checker.sv
tb/sv/tb_refcount_deferred_reclaim_table_core.sv
